>>> rtl/stable_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stable priority queue
// Clocked, reset-gated concurrent assertion wrappers.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// Generic form with explicit clock and active-low reset.
`define SPQ_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Default clock and reset of the block.
`define SPQ_ASSERT(lbl, prop, msg) \
  `SPQ_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

// Condition must never hold.
`define SPQ_ASSERT_NEVER(lbl, cond, msg) \
  `SPQ_ASSERT(lbl, !(cond), msg)

`endif

>>> rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Types, sizes and codes shared by the stable priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int Depth      = 16;
  localparam int PrioBits   = 8;
  localparam int HandleBits = 16;
  localparam int AddrBits   = $clog2(Depth);
  localparam int CntBits    = $clog2(Depth + 1);

  localparam logic OpInsert = 1'b0;
  localparam logic OpRemove = 1'b1;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusFull  = 2'd2;

  typedef struct packed {
    logic                  opcode;
    logic [PrioBits-1:0]   priority_req;
    logic [HandleBits-1:0] handle;
  } spq_req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [PrioBits-1:0]   out_priority;
    logic [HandleBits-1:0] out_handle;
    logic                  is_empty;
    logic [CntBits-1:0]    fill_count;
  } spq_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;       // capture request, pos = count
    logic       rd;         // issue memory read
    logic       rd_head;    // read at head, else at pos - 1
    logic       shift;      // move read entry up to pos, pos--
    logic       ins_write;  // write new entry at pos, count++
    logic       pop;        // drop head, count--
    logic       resp;       // launch a result transfer
    logic [1:0] status;
  } spq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic rd_greater;
  } spq_stat_t;

endpackage

>>> rtl/spq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer for insert (tail-to-head shift search) and remove (head pop).
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      opcode_i,
  input  spq_stat_t stat_i,
  output spq_cmd_t  cmd_o,
  output logic      busy
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StInsRd  = 3'd1;
  localparam logic [2:0] StInsCmp = 3'd2;
  localparam logic [2:0] StInsWr  = 3'd3;
  localparam logic [2:0] StRemOut = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = StatusOk;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          if (opcode_i == OpInsert) begin
            if (stat_i.full) begin
              cmd_o.resp   = 1'b1;
              cmd_o.status = StatusFull;
            end else begin
              cmd_o.load = 1'b1;
              state_d    = StInsRd;
            end
          end else begin
            if (stat_i.empty) begin
              cmd_o.resp   = 1'b1;
              cmd_o.status = StatusEmpty;
            end else begin
              cmd_o.rd      = 1'b1;
              cmd_o.rd_head = 1'b1;
              state_d       = StRemOut;
            end
          end
        end
      end
      StInsRd: begin
        if (stat_i.pos_zero) begin
          state_d = StInsWr;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = StInsCmp;
        end
      end
      StInsCmp: begin
        if (stat_i.rd_greater) begin
          cmd_o.shift = 1'b1;
          state_d     = StInsRd;
        end else begin
          state_d = StInsWr;
        end
      end
      StInsWr: begin
        cmd_o.ins_write = 1'b1;
        cmd_o.resp      = 1'b1;
        state_d         = StIdle;
      end
      StRemOut: begin
        cmd_o.pop  = 1'b1;
        cmd_o.resp = 1'b1;
        state_d    = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != StIdle);

endmodule

>>> rtl/spq_datapath.sv
`timescale 1ns / 1ps
`include "stable_priority_queue_assert.svh"
// ----------------------------------------------------------------------------
// spq_datapath
// Circular entry store with head pointer, fill count, search position and
// result register.
// ----------------------------------------------------------------------------
module spq_datapath
  import spq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  spq_req_t req_i,
  input  spq_cmd_t cmd_i,
  output spq_stat_t stat_o,
  output logic     done_o,
  output spq_rsp_t rsp_o
);

  localparam logic [AddrBits:0] DepthWide = (AddrBits + 1)'(Depth);
  localparam logic [CntBits-1:0] DepthCnt = CntBits'(Depth);

  logic [PrioBits-1:0]   mem_prio [Depth];
  logic [HandleBits-1:0] mem_hnd  [Depth];

  logic [AddrBits-1:0]   head_q, head_d;
  logic [CntBits-1:0]    count_q, count_d;
  logic [CntBits-1:0]    pos_q, pos_d;
  logic [PrioBits-1:0]   prio_q;
  logic [HandleBits-1:0] hnd_q;
  logic [PrioBits-1:0]   rd_prio_q;
  logic [HandleBits-1:0] rd_hnd_q;
  logic                  done_q;
  spq_rsp_t              rsp_q;

  logic [AddrBits-1:0]   rd_ofs, rd_addr, wr_addr;
  logic                  we;
  logic [PrioBits-1:0]   wr_prio;
  logic [HandleBits-1:0] wr_hnd;

  function automatic logic [AddrBits-1:0] phys_addr(input logic [AddrBits-1:0] base,
                                                     input logic [AddrBits-1:0] ofs);
    logic [AddrBits:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= DepthWide) sum = sum - DepthWide;
    return sum[AddrBits-1:0];
  endfunction

  assign rd_ofs  = cmd_i.rd_head ? '0 : AddrBits'(pos_q - CntBits'(1));
  assign rd_addr = phys_addr(head_q, rd_ofs);
  assign wr_addr = phys_addr(head_q, pos_q[AddrBits-1:0]);
  assign we      = cmd_i.shift | cmd_i.ins_write;
  assign wr_prio = cmd_i.shift ? rd_prio_q : prio_q;
  assign wr_hnd  = cmd_i.shift ? rd_hnd_q  : hnd_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_prio[wr_addr] <= wr_prio;
      mem_hnd[wr_addr]  <= wr_hnd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_prio_q <= mem_prio[rd_addr];
      rd_hnd_q  <= mem_hnd[rd_addr];
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    pos_d   = pos_q;
    if (cmd_i.load)      pos_d = count_q;
    if (cmd_i.shift)     pos_d = pos_q - CntBits'(1);
    if (cmd_i.ins_write) count_d = count_q + CntBits'(1);
    if (cmd_i.pop) begin
      count_d = count_q - CntBits'(1);
      head_d  = phys_addr(head_q, AddrBits'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      done_q  <= cmd_i.resp;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (cmd_i.load) begin
      prio_q <= req_i.priority_req;
      hnd_q  <= req_i.handle;
    end
    if (cmd_i.resp) begin
      rsp_q.status       <= cmd_i.status;
      rsp_q.out_priority <= cmd_i.pop ? rd_prio_q : '0;
      rsp_q.out_handle   <= cmd_i.pop ? rd_hnd_q  : '0;
      rsp_q.is_empty     <= (count_d == '0);
      rsp_q.fill_count   <= count_d;
    end
  end

  assign stat_o.full       = (count_q == DepthCnt);
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.pos_zero   = (pos_q == '0);
  assign stat_o.rd_greater = (rd_prio_q > prio_q);

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `SPQ_ASSERT_NEVER(a_count_range, count_q > DepthCnt, "fill count above depth")
  `SPQ_ASSERT(a_done_count, done_q |-> rsp_q.fill_count == count_q, "result count stale")
  `SPQ_ASSERT(a_pop_nonempty, cmd_i.pop |-> count_q != '0, "pop on empty store")
  `SPQ_ASSERT(a_ins_notfull, cmd_i.ins_write |-> count_q != DepthCnt, "write into full store")
  `SPQ_ASSERT(a_shift_pos, cmd_i.shift |-> pos_q != '0, "shift below head")

endmodule

>>> rtl/stable_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue
// Stable sorted queue of (priority, handle) pairs; lower value served first,
// equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
//  Channel   Ports                    Transfer
//  request   start, busy, req_i       start high while busy low
//  result    done_o, rsp_o            done_o high, one cycle, no backpressure
//
//  Remove: head read, then pop. Rejected remove/insert: answered from idle.
//  Insert: load, then a read and compare per stored entry, moving each entry
//  with a higher priority value up one place, then the new entry's write;
//  each moved entry costs one read and one write on the store.
//  The result appears the cycle after the last step; busy is low again then.
//  Reset clears the fill count and head pointer; entry storage is not cleared.
// ----------------------------------------------------------------------------
module stable_priority_queue
  import spq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  spq_req_t req_i,
  output logic     busy,
  output logic     done_o,
  output spq_rsp_t rsp_o
);

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (req_i.opcode),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  spq_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

>>> bench/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Watches the request and result channels of the stable priority queue. It
// keeps its own sorted copy of the queue, computes the result of every
// accepted request and compares each result strobe against the oldest one.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  spq_req_t    req_i,
  input  logic        done_i,
  input  spq_rsp_t    rsp_i,
  output int unsigned err_cnt_o,
  output int unsigned pending_o,
  output int unsigned full_cnt_o,
  output int unsigned empty_cnt_o
);

  logic [PrioBits-1:0]   slot_prio[Depth];
  logic [HandleBits-1:0] slot_handle[Depth];
  int                    fill;

  spq_rsp_t    expected_rsp[$];
  spq_rsp_t    exp_r;
  spq_rsp_t    next_r;
  int unsigned errors;
  int unsigned pending;
  int unsigned full_drops;
  int unsigned empty_pops;

  initial begin
    fill       = 0;
    errors     = 0;
    pending    = 0;
    full_drops = 0;
    empty_pops = 0;
  end

  assign err_cnt_o   = errors;
  assign pending_o   = pending;
  assign full_cnt_o  = full_drops;
  assign empty_cnt_o = empty_pops;

  // Apply one request to the sorted copy; returns the result it must produce.
  task automatic queue_update(input spq_req_t r, output spq_rsp_t res);
    int pos;
    int i;
    res        = '0;
    res.status = StatusOk;
    if (r.opcode == OpInsert) begin
      if (fill >= Depth) begin
        res.status = StatusFull;
      end else begin
        pos = 0;
        // stable: new entry goes behind every entry of equal or lower value
        while (pos < fill && slot_prio[pos] <= r.priority_req) pos++;
        for (i = fill; i > pos; i--) begin
          slot_prio[i]   = slot_prio[i-1];
          slot_handle[i] = slot_handle[i-1];
        end
        slot_prio[pos]   = r.priority_req;
        slot_handle[pos] = r.handle;
        fill++;
      end
    end else if (fill == 0) begin
      res.status = StatusEmpty;
    end else begin
      res.out_priority = slot_prio[0];
      res.out_handle   = slot_handle[0];
      for (i = 1; i < fill; i++) begin
        slot_prio[i-1]   = slot_prio[i];
        slot_handle[i-1] = slot_handle[i];
      end
      fill--;
    end
    res.is_empty   = (fill == 0);
    res.fill_count = CntBits'(fill);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill    = 0;
      pending = 0;
      expected_rsp.delete();
    end else begin
      // result first: a transfer may start on the edge that ends a result
      if (done_i) begin
        if (pending == 0) begin
          errors++;
          $display("%0t: result with none pending, expected nothing, actual %p",
                   $time, rsp_i);
        end else begin
          exp_r = expected_rsp.pop_front();
          pending--;
          check_field("status", exp_r.status, rsp_i.status);
          check_field("out_priority", exp_r.out_priority, rsp_i.out_priority);
          check_field("out_handle", exp_r.out_handle, rsp_i.out_handle);
          check_field("is_empty", exp_r.is_empty, rsp_i.is_empty);
          check_field("fill_count", exp_r.fill_count, rsp_i.fill_count);
        end
      end
      if (start_i && !busy_i) begin
        queue_update(req_i, next_r);
        if (next_r.status == StatusFull) full_drops++;
        if (next_r.status == StatusEmpty) empty_pops++;
        expected_rsp.push_back(next_r);
        pending++;
      end
    end
  end

endmodule

>>> bench/tb_stable_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_priority_queue
// Drives the stable priority queue with a directed run (empty remove, extreme
// priorities and handles, ties, fill to full and overflow) followed by random
// insert/remove traffic under three sender idle profiles. Checking is done by
// spq_checker, which this top instantiates next to the block.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue;
  import spq_pkg::*;

  localparam int PhaseItems = 633;
  localparam int DrainWait  = 40;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  spq_req_t req_i  = '0;
  logic     busy;
  logic     done_o;
  spq_rsp_t rsp_o;

  int unsigned err_cnt;
  int unsigned pending;
  int unsigned full_cnt;
  int unsigned empty_cnt;
  int unsigned n_insert = 0;
  int unsigned n_remove = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  stable_priority_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  spq_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req_i),
    .done_i      (done_o),
    .rsp_i       (rsp_o),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending),
    .full_cnt_o  (full_cnt),
    .empty_cnt_o (empty_cnt)
  );

  function automatic spq_req_t make_req(input logic op, input logic [PrioBits-1:0] prio,
                                        input logic [HandleBits-1:0] hnd);
    spq_req_t r;
    r.opcode       = op;
    r.priority_req = prio;
    r.handle       = hnd;
    return r;
  endfunction

  function automatic spq_req_t rand_req(input int unsigned ins_pct);
    logic [PrioBits-1:0] prio;
    case ($urandom_range(9))
      0:       prio = '0;
      1:       prio = '1;
      2, 3, 4: prio = PrioBits'($urandom_range(255));
      default: prio = PrioBits'($urandom_range(3));  // dense ties
    endcase
    return make_req(($urandom_range(99) < ins_pct) ? OpInsert : OpRemove, prio,
                    HandleBits'($urandom_range(16'hFFFF)));
  endfunction

  // Called right after a rising edge; returns right after the transfer edge.
  task automatic send(input spq_req_t r, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    if (r.opcode == OpInsert) n_insert++;
    else n_remove++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned idle_pct;
    int unsigned ins_pct;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send(make_req(OpRemove, 8'hFF, 16'hFFFF), 0);
    send(make_req(OpInsert, 8'hFF, 16'hFFFF), 0);
    send(make_req(OpInsert, 8'h00, 16'h0000), 0);
    send(make_req(OpInsert, 8'hFF, 16'h1234), 0);
    send(make_req(OpInsert, 8'h00, 16'h0001), 0);
    send(make_req(OpInsert, 8'h80, 16'hAAAA), 0);
    for (int i = 0; i < 11; i++)
      send(make_req(OpInsert, PrioBits'((i % 3) * 100), HandleBits'(16'h5500 + i)), 0);
    send(make_req(OpInsert, 8'h07, 16'h5555), 0);
    for (int i = 0; i < 4; i++)
      send(make_req(OpRemove, PrioBits'($urandom_range(255)),
                    HandleBits'($urandom_range(16'hFFFF))), 0);
    send(make_req(OpInsert, 8'h00, 16'hFFFE), 0);
    wait_drained();

    // random: sender idles 20%, then 61%, then not at all
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 20 : (ph == 1) ? 61 : 0;
      ins_pct  = 50;
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 30 == 0) begin
          case ($urandom_range(3))
            0:       ins_pct = 25;
            1:       ins_pct = 50;
            2:       ins_pct = 75;
            default: ins_pct = 90;
          endcase
        end
        send(rand_req(ins_pct), idle_pct);
      end
      wait_drained();
    end

    repeat (DrainWait) @(posedge clk_i);
    $display("Ran %0d inserts and %0d removes across three sender idle profiles",
             n_insert, n_remove);
    $display("%0d inserts met a full queue, %0d removes met an empty one",
             full_cnt, empty_cnt);
    if (err_cnt == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/stable_priority_queue.sv
bench/spq_checker.sv
bench/tb_stable_priority_queue.sv
